/* rtl/i2cbw_pkg.sv */
// Shared types and constants for the I2C bit-bang write sequencer.
`default_nettype none

package i2cbw_pkg;

  // Message length in bytes and number of clock lines that may be selected
  localparam int unsigned MessageBytes = 3;
  localparam int unsigned NumTargets   = 4;

  localparam int unsigned MsgWidth  = 24;
  localparam int unsigned LineWidth = 4;
  localparam int unsigned ByteWidth = 8;

  // Request commands
  localparam logic CmdTick  = 1'b0;
  localparam logic CmdStart = 1'b1;

  // Clock lines that a select may address
  localparam logic [LineWidth-1:0] TargetMask = LineWidth'((1 << NumTargets) - 1);

  // Bit mask values at the start and end of a byte
  localparam logic [ByteWidth-1:0] MaskFirst = 8'h80;
  localparam logic [ByteWidth-1:0] MaskLast  = 8'h01;

  typedef struct packed {
    logic                 command;
    logic [MsgWidth-1:0]  message;
    logic [LineWidth-1:0] target_select;
  } in_item_t;

  typedef struct packed {
    logic [LineWidth-1:0] clock_lines;
    logic                 data_level;
    logic                 data_drive;
    logic                 busy_res;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/i2cbw_in_reg.sv */
// Input register stage: holds one request ahead of the sequencing logic.
`default_nettype none

module i2cbw_in_reg
  import i2cbw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     req_valid_o,
  input  logic     req_stall_i,
  output in_item_t req_item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q, item_d;
  logic     load;

  // Hold the request only while the next stage is stalled
  assign in_stall_o = valid_q & req_stall_i;
  assign load       = ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        item_d = in_item_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload carries no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign req_valid_o = valid_q;
  assign req_item_o  = item_q;

endmodule

`default_nettype wire

/* rtl/i2cbw_step.sv */
// Phase sequencer: line state, one phase step per tick, and the result register.
`default_nettype none

module i2cbw_step
  import i2cbw_pkg::*;
#(
  parameter int unsigned MsgBytes = MessageBytes,
  parameter int unsigned Targets  = NumTargets
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_stall_o,
  input  in_item_t  req_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [3:0] {
    PhStart     = 4'd0,
    PhLoadByte  = 4'd1,
    PhClkLow    = 4'd2,
    PhPutBit    = 4'd3,
    PhClkHigh   = 4'd4,
    PhAckLow    = 4'd5,
    PhAckRaise  = 4'd6,
    PhAckFree   = 4'd7,
    PhAckHigh   = 4'd8,
    PhAckEnd    = 4'd9,
    PhRedrive   = 4'd10,
    PhPullLow   = 4'd11,
    PhStopClk   = 4'd12,
    PhStopData  = 4'd13,
    PhIdle      = 4'd14
  } phase_e;

  // Clock lines that a select may address with this many targets
  localparam logic [LineWidth-1:0] SelMask = LineWidth'((1 << Targets) - 1);

  phase_e               phase_q, phase_d;
  logic [MsgWidth-1:0]  shift_q, shift_d;
  logic [LineWidth-1:0] choice_q, choice_d;
  logic [1:0]           left_q, left_d;
  logic [ByteWidth-1:0] byte_q, byte_d;
  logic [ByteWidth-1:0] mask_q, mask_d;
  logic [LineWidth-1:0] clock_q, clock_d;
  logic                 data_q, data_d;
  logic                 drive_q, drive_d;

  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic                 advance;
  logic [LineWidth-1:0] sel_line;
  logic                 sel_ok;

  // Accept a request whenever the result register is free or being emptied
  assign req_stall_o = out_valid_q & out_stall_i;
  assign advance     = req_valid_i & ~req_stall_o;

  // Selected clock line: only a one-hot select within range moves a line
  assign sel_ok   = (choice_q != '0)
                  && ((choice_q & (choice_q - 1'b1)) == '0)
                  && ((choice_q & SelMask) != '0);
  assign sel_line = sel_ok ? choice_q : '0;

  // Next state for one request
  always_comb begin
    phase_d  = phase_q;
    shift_d  = shift_q;
    choice_d = choice_q;
    left_d   = left_q;
    byte_d   = byte_q;
    mask_d   = mask_q;
    clock_d  = clock_q;
    data_d   = data_q;
    drive_d  = drive_q;
    if (req_item_i.command == CmdStart) begin
      shift_d  = req_item_i.message;
      choice_d = req_item_i.target_select;
      phase_d  = PhStart;
    end else begin
      case (phase_q)
        PhStart: begin
          left_d  = 2'(MsgBytes);
          data_d  = 1'b0;
          phase_d = PhLoadByte;
        end
        PhLoadByte: begin
          clock_d = clock_q & ~sel_line;
          byte_d  = shift_q[ByteWidth-1:0];
          mask_d  = MaskFirst;
          phase_d = PhPutBit;
        end
        PhClkLow: begin
          clock_d = clock_q & ~sel_line;
          phase_d = PhPutBit;
        end
        PhPutBit: begin
          data_d  = (byte_q & mask_q) != '0;
          phase_d = PhClkHigh;
        end
        PhClkHigh: begin
          clock_d = clock_q | sel_line;
          if (mask_q != MaskLast) begin
            mask_d  = mask_q >> 1;
            phase_d = PhClkLow;
          end else begin
            left_d  = left_q - 2'd1;
            shift_d = shift_q >> ByteWidth;
            phase_d = PhAckLow;
          end
        end
        PhAckLow: begin
          clock_d = clock_q & ~sel_line;
          phase_d = PhAckRaise;
        end
        PhAckRaise: begin
          data_d  = 1'b1;
          phase_d = PhAckFree;
        end
        PhAckFree: begin
          drive_d = 1'b0;
          phase_d = PhAckHigh;
        end
        PhAckHigh: begin
          clock_d = clock_q | sel_line;
          phase_d = PhAckEnd;
        end
        PhAckEnd: begin
          clock_d = clock_q & ~sel_line;
          phase_d = PhRedrive;
        end
        PhRedrive: begin
          drive_d = 1'b1;
          phase_d = PhPullLow;
        end
        PhPullLow: begin
          data_d  = 1'b0;
          phase_d = (left_q == 2'd0) ? PhStopClk : PhLoadByte;
        end
        PhStopClk: begin
          clock_d = clock_q | sel_line;
          phase_d = PhStopData;
        end
        PhStopData: begin
          data_d  = 1'b1;
          phase_d = PhIdle;
        end
        PhIdle: begin
          phase_d = PhIdle;
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  // Result register follows the updated state
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d       = 1'b1;
      out_d.clock_lines = clock_d;
      out_d.data_level  = data_d;
      out_d.data_drive  = drive_d;
      out_d.busy_res    = (phase_d != PhIdle);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      shift_q     <= '0;
      choice_q    <= '0;
      left_q      <= '0;
      byte_q      <= '0;
      mask_q      <= '0;
      clock_q     <= '1;
      data_q      <= 1'b1;
      drive_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        phase_q  <= phase_d;
        shift_q  <= shift_d;
        choice_q <= choice_d;
        left_q   <= left_d;
        byte_q   <= byte_d;
        mask_q   <= mask_d;
        clock_q  <= clock_d;
        data_q   <= data_d;
        drive_q  <= drive_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* rtl/i2c_bitbang_write_sequencer.sv */
// Top level of the tick-driven I2C write sequencer.
//
// Takes one request per clock cycle when the output side keeps up; each request
// gives exactly one result once accepted: it is held in the input register, then
// passes through the phase logic into the result register. A start request
// loads a three-byte message (low byte first, bits MSB first) and a one-hot
// clock-line select; each tick request then advances the bus one phase and the
// result shows the line levels afterwards. While a result waits in the result
// register one more request can still enter the input register; the input
// stalls only once that register is full as well. A select that is not one-hot
// leaves the clock lines alone.
`default_nettype none

module i2c_bitbang_write_sequencer
  import i2cbw_pkg::*;
#(
  parameter int unsigned MsgBytes = MessageBytes,
  parameter int unsigned Targets  = NumTargets
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic     req_valid;
  logic     req_stall;
  in_item_t req_item;

  i2cbw_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .req_valid_o (req_valid),
    .req_stall_i (req_stall),
    .req_item_o  (req_item)
  );

  i2cbw_step #(
    .MsgBytes (MsgBytes),
    .Targets  (Targets)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_stall_o (req_stall),
    .req_item_i  (req_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* rtl/i2cbw_checker.sv */
// Port-level checks for the I2C write sequencer, bound to the top level.
`default_nettype none

module i2cbw_checker
  import i2cbw_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Input side only stalls when the result side is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // When idle the data line is high and driven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.busy_res |-> out_item_o.data_level && out_item_o.data_drive)
    else $error("idle result with data line low or released");

  // A fresh result follows a request that was accepted at the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching request");

endmodule

bind i2c_bitbang_write_sequencer i2cbw_checker u_i2cbw_checker (.*);

`default_nettype wire
